// ----- hdl/rdqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rdqs_pkg
// Shared constants for the ring deque with search: codes, widths, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package rdqs_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ACT_W  = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int IN_W   = ((ACT_W + DATA_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_PUSH_F = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_B = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_F  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SRCH_F = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SRCH_B = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MAX    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/rdqs_ram.sv -----
// ----------------------------------------------------------------------------
// rdqs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rdqs_ram #(
    parameter int WIDTH = rdqs_pkg::DATA_W,
    parameter int DEPTH = rdqs_pkg::CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/ring_deque_with_search_top.sv -----
// Pushes, unknown actions and pop, search or maximum requests on an empty queue
//   give their word in the cycle after acceptance; a pop waits for its RAM read.
// Search and maximum walk the queue, reading one stored element per cycle
//   through the single read port of the element RAM; a search stops at a match.
// One request at a time: the next word is taken once the result has been taken.
// Synchronous active-low reset empties the queue; the element RAM is not cleared.
// ----------------------------------------------------------------------------
// ring_deque_with_search_top
// Bounded double-ended queue in a ring RAM with front/back search and maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_deque_with_search_top #(
    parameter int CAPACITY = rdqs_pkg::CAPACITY_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    // action[2:0], value[34:3], zero padding
    input  wire logic [rdqs_pkg::IN_W-1:0] i_s_tdata,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    // result_value[31:0], status[33:32], occupancy above, zero padding
    output logic [((34 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((34 + CNT_W + 7) / 8) * 8;
    localparam int DW    = rdqs_pkg::DATA_W;
    localparam int SW    = rdqs_pkg::STAT_W;
    localparam int AW    = rdqs_pkg::ACT_W;

    localparam logic [IDX_W:0]   CAP_X   = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CAPACITY - 1);

    rdqs_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_iss,   n_iss;
    logic [IDX_W-1:0] r_pidx,  n_pidx;
    logic             r_pend,  n_pend;
    logic [AW-1:0]    r_act,   n_act;
    logic [DW-1:0]    r_value, n_value;
    logic [DW-1:0]    r_best,  n_best;
    logic             r_out_vld, n_out_vld;
    logic [DW-1:0]    r_res,   n_res;
    logic [SW-1:0]    r_sta,   n_sta;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [DW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [DW-1:0]    ram_rdata;

    logic [AW-1:0]    in_act;
    logic [DW-1:0]    in_val;
    logic             accept;
    logic [CNT_W-1:0] back_off;
    logic [IDX_W-1:0] walk_off;
    logic [CNT_W-1:0] walk_lim;
    logic             last;
    logic [DW-1:0]    best_nx;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
                                              input logic [IDX_W-1:0] o);
        logic [IDX_W:0] s;
        s = {1'b0, h} + {1'b0, o};
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[IDX_W-1:0];
    endfunction

    assign in_act = i_s_tdata[AW-1:0];
    assign in_val = i_s_tdata[AW +: DW];

    assign o_s_tready = (r_state == rdqs_pkg::S_IDLE) && !r_out_vld;
    assign accept     = i_s_tvalid && o_s_tready;

    assign back_off  = r_count - CNT_W'(1) - r_iss;
    assign walk_off  = (r_act == rdqs_pkg::ACT_SRCH_B) ? back_off[IDX_W-1:0]
                                                       : r_iss[IDX_W-1:0];
    assign walk_lim  = (r_act == rdqs_pkg::ACT_POP_F) ? CNT_W'(1) : r_count;
    assign last      = (CNT_W'(r_pidx) == r_count - CNT_W'(1));
    assign best_nx   = ($signed(ram_rdata) > $signed(r_best)) ? ram_rdata : r_best;
    assign head_dec  = (r_head == '0) ? IDX_MAX : r_head - IDX_W'(1);
    assign head_inc  = (r_head == IDX_MAX) ? '0 : r_head + IDX_W'(1);
    assign ram_raddr = slot(r_head, walk_off);
    assign ram_wdata = in_val;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_iss     = r_iss;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_act     = r_act;
        n_value   = r_value;
        n_best    = r_best;
        n_out_vld = r_out_vld;
        n_res     = r_res;
        n_sta     = r_sta;
        ram_we    = 1'b0;
        ram_waddr = slot(r_head, r_count[IDX_W-1:0]);

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            rdqs_pkg::S_IDLE: begin
                if (accept) begin
                    n_act     = in_act;
                    n_value   = in_val;
                    n_iss     = '0;
                    n_pend    = 1'b0;
                    n_best    = '0;
                    n_res     = '0;
                    n_sta     = rdqs_pkg::ST_OK;
                    n_out_vld = 1'b1;
                    case (in_act) inside
                        rdqs_pkg::ACT_PUSH_F, rdqs_pkg::ACT_PUSH_B: begin
                            if (r_count >= CAP_C) begin
                                n_sta = rdqs_pkg::ST_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (in_act == rdqs_pkg::ACT_PUSH_F) begin
                                    ram_waddr = head_dec;
                                    n_head    = head_dec;
                                end
                            end
                        end
                        rdqs_pkg::ACT_POP_F, rdqs_pkg::ACT_SRCH_F,
                        rdqs_pkg::ACT_SRCH_B, rdqs_pkg::ACT_MAX: begin
                            if (r_count == '0) begin
                                n_sta = rdqs_pkg::ST_EMPTY;
                            end else begin
                                n_out_vld = 1'b0;
                                n_state   = rdqs_pkg::S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rdqs_pkg::S_WALK: begin
                if (r_iss < walk_lim) begin
                    n_iss  = r_iss + CNT_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_iss[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    case (r_act) inside
                        rdqs_pkg::ACT_POP_F: begin
                            n_res     = ram_rdata;
                            n_head    = head_inc;
                            n_count   = r_count - CNT_W'(1);
                            n_out_vld = 1'b1;
                            n_state   = rdqs_pkg::S_IDLE;
                        end
                        rdqs_pkg::ACT_SRCH_F, rdqs_pkg::ACT_SRCH_B: begin
                            if (ram_rdata == r_value) begin
                                n_res     = DW'(r_pidx);
                                n_out_vld = 1'b1;
                                n_state   = rdqs_pkg::S_IDLE;
                            end else if (last) begin
                                n_sta     = rdqs_pkg::ST_NOTFOUND;
                                n_out_vld = 1'b1;
                                n_state   = rdqs_pkg::S_IDLE;
                            end
                        end
                        default: begin
                            n_best = best_nx;
                            if (last) begin
                                n_res     = best_nx;
                                n_out_vld = 1'b1;
                                n_state   = rdqs_pkg::S_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = rdqs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rdqs_pkg::S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss   <= n_iss;
        r_pidx  <= n_pidx;
        r_act   <= n_act;
        r_value <= n_value;
        r_best  <= n_best;
        r_res   <= n_res;
        r_sta   <= n_sta;
    end

    rdqs_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_count, r_sta, r_res});

endmodule

`default_nettype wire

// ----- hdl/rdqs_chk.sv -----
// ----------------------------------------------------------------------------
// rdqs_chk
// Port-level checks for the ring deque with search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdqs_chk #(
    parameter int CAPACITY = rdqs_pkg::CAPACITY_DEF
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      o_s_tready,
    input wire logic [rdqs_pkg::IN_W-1:0] i_s_tdata,
    input wire logic                      o_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [((34 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [31:0]      res;
    logic [1:0]       sta;
    logic [CNT_W-1:0] occ;

    assign res = o_m_tdata[31:0];
    assign sta = o_m_tdata[33:32];
    assign occ = o_m_tdata[34 +: CNT_W];

    a_no_ready_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a result word is pending");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (occ <= CNT_W'(CAPACITY)))
        else $error("occupancy beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && sta == rdqs_pkg::ST_FULL) |->
            (occ == CNT_W'(CAPACITY) && res == '0))
        else $error("full status with wrong occupancy or value");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && sta == rdqs_pkg::ST_EMPTY) |-> (occ == '0 && res == '0))
        else $error("empty status with wrong occupancy or value");

endmodule

bind ring_deque_with_search_top rdqs_chk #(.CAPACITY(CAPACITY)) u_rdqs_chk (.*);

`default_nettype wire
